@@ rtl/goe_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the glyph outline expander.
// Used by every module under rtl; depends on nothing else.
package goe_pkg;

  localparam int GridSize = 16;
  localparam int RowW     = 32;
  localparam int PackW    = 2 * GridSize;
  localparam int WidthW   = 5;
  localparam int CntW     = $clog2(GridSize + 1);
  localparam int ShiftW   = $clog2(PackW + 1);
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  localparam logic [1:0] CodeEmpty = 2'd0;
  localparam logic [1:0] CodeInk   = 2'd1;
  localparam logic [1:0] CodeEdge  = 2'd2;

  typedef struct packed {
    logic ink;
    logic left;
    logic right;
    logic up;
    logic down;
    logic en;
  } nbr_t;

  typedef struct packed {
    logic             last;
    logic [PackW-1:0] packed_row;
  } result_t;

  function automatic logic [GridSize-1:0] width_mask(input logic [WidthW-1:0] w);
    logic [GridSize-1:0] m;
    m = '0;
    for (int i = 0; i < GridSize; i++) begin
      m[GridSize-1-i] = (i < int'(w));
    end
    return m;
  endfunction

endpackage

@@ rtl/goe_lane.sv @@
`timescale 1ns / 1ps
// One pixel lane: turns a pixel and its four neighbors into a 2-bit code.
// Depends on goe_pkg.
module goe_lane (
  input  goe_pkg::nbr_t   nbr_i,
  output logic [1:0]      code_o
);
  import goe_pkg::*;

  always_comb begin
    if (nbr_i.ink && nbr_i.en) begin
      code_o = CodeInk;
    end else if (nbr_i.en && (nbr_i.left || nbr_i.right || nbr_i.up || nbr_i.down)) begin
      code_o = CodeEdge;
    end else begin
      code_o = CodeEmpty;
    end
  end

endmodule

@@ rtl/goe_row_pack.sv @@
`timescale 1ns / 1ps
// A row of pixel lanes over a three-row window, merged into one right-aligned packed row.
// Depends on goe_pkg and goe_lane.
module goe_row_pack (
  input  logic [goe_pkg::GridSize-1:0] above_i,
  input  logic [goe_pkg::GridSize-1:0] cur_i,
  input  logic [goe_pkg::GridSize-1:0] below_i,
  input  logic [goe_pkg::GridSize-1:0] mask_i,
  input  logic [goe_pkg::ShiftW-1:0]   shift_i,
  output logic [goe_pkg::PackW-1:0]    packed_o
);
  import goe_pkg::*;

  logic [GridSize-1:0] above_m;
  logic [GridSize-1:0] cur_m;
  logic [GridSize-1:0] below_m;
  logic [GridSize-1:0] cur_hi;
  logic [GridSize-1:0] cur_lo;
  logic [PackW-1:0]    full;

  assign above_m = above_i & mask_i;
  assign cur_m   = cur_i & mask_i;
  assign below_m = below_i & mask_i;
  assign cur_hi  = {1'b0, cur_m[GridSize-1:1]};
  assign cur_lo  = {cur_m[GridSize-2:0], 1'b0};

  for (genvar k = 0; k < GridSize; k++) begin : g_lane
    nbr_t nbr;
    assign nbr.ink   = cur_m[k];
    assign nbr.left  = cur_hi[k];
    assign nbr.right = cur_lo[k];
    assign nbr.up    = above_m[k];
    assign nbr.down  = below_m[k];
    assign nbr.en    = mask_i[k];

    goe_lane u_lane (
      .nbr_i  (nbr),
      .code_o (full[2*k+1:2*k])
    );
  end

  assign packed_o = full >> shift_i;

endmodule

@@ rtl/goe_outq.sv @@
`timescale 1ns / 1ps
// Four-entry result queue that takes up to two results per cycle and hands out one per cycle while ready_i is high.
// Depends on goe_pkg.
module goe_outq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                push_cnt_i,
  input  goe_pkg::result_t          push0_i,
  input  goe_pkg::result_t          push1_i,
  output logic                      room_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output goe_pkg::result_t          head_o
);
  import goe_pkg::*;

  result_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;
  logic              pop;

  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= QCntW'(QDepth - 2));
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + QPtrW'(pop);
    count_d  = count_q + QCntW'(push_cnt_i) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + QPtrW'(1)] <= push1_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("result queue count exceeds depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i != 2'd0 |-> count_q <= QCntW'(QDepth - 2))
    else $error("result pushed without room for two");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QPtrW'(wr_ptr_q - rd_ptr_q) == count_q[QPtrW-1:0])
    else $error("queue pointers disagree with count");

endmodule

@@ rtl/glyph_outline_expander.sv @@
`timescale 1ns / 1ps
// Top level of the glyph outline expander: row window, two lane banks and result queue.
// Depends on goe_pkg, goe_row_pack and goe_outq.
//
// Usage: a 1-bit glyph enters one row per request on the s_axis channel, pixel 0 in
// tdata bit 31, with tlast on the final row of the glyph. Each row comes back on the
// m_axis channel as 2-bit pixels (0 empty, 1 ink, 2 outline) packed leftmost first in
// the low 2*width bits of tdata. A row is released when the row below it arrives; the
// final row, or the sixteenth, is released on its own request with tlast set, so one
// request yields zero, one or two results. Rows after the sixteenth are dropped until
// the row that carries tlast.
// Results are registered in the result queue. Throughput is one row per cycle while
// s_axis_tready is high; both results of a request are computed in the same cycle by
// two banks of sixteen pixel lanes and written together into a four-entry result queue.
// s_axis_tready stays high while the queue holds at most two results, so a stalled
// receiver back-pressures the sender after at most four results are waiting.
// Reset clears the row window and the queue and sets the glyph width to 16. The width
// is written through cfg_we_i and cfg_wdata_i while no request is in flight.
module glyph_outline_expander (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [goe_pkg::WidthW-1:0]   cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [goe_pkg::RowW-1:0]     s_axis_tdata,  // row_bits[31:0]
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [goe_pkg::PackW-1:0]    m_axis_tdata,  // packed_row[31:0]
  output logic                         m_axis_tlast
);
  import goe_pkg::*;

  logic [WidthW-1:0]   width_q;
  logic [GridSize-1:0] above_q;
  logic [GridSize-1:0] pending_q;
  logic [CntW-1:0]     rows_seen_q;

  logic [WidthW-1:0]   used_w;
  logic [GridSize-1:0] mask;
  logic [ShiftW-1:0]   shift;
  logic [GridSize-1:0] row_in;
  logic [GridSize-1:0] row_new;
  logic [GridSize-1:0] next_above;
  logic                accept;
  logic                started;
  logic                full_glyph;
  logic                hits_limit;
  logic                push_a;
  logic                push_b;
  logic [1:0]          push_cnt;
  logic [PackW-1:0]    pack_a;
  logic [PackW-1:0]    pack_b;
  result_t             res_a;
  result_t             res_b;
  result_t             push0;
  result_t             head;
  logic                room;

  assign used_w     = (width_q > WidthW'(GridSize)) ? WidthW'(GridSize) : width_q;
  assign mask       = width_mask(used_w);
  assign shift      = ShiftW'(PackW) - ShiftW'({used_w, 1'b0});
  assign row_in     = s_axis_tdata[RowW-1 -: GridSize];
  assign row_new    = row_in & mask;
  assign started    = (rows_seen_q != '0);
  assign full_glyph = (rows_seen_q >= CntW'(GridSize));
  assign hits_limit = (rows_seen_q == CntW'(GridSize - 1));
  assign next_above = started ? pending_q : '0;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_a        = accept && !full_glyph && started;
  assign push_b        = accept && !full_glyph && (s_axis_tlast || hits_limit);
  assign push_cnt      = {1'b0, push_a} + {1'b0, push_b};

  goe_row_pack u_pack_a (
    .above_i  (above_q),
    .cur_i    (pending_q),
    .below_i  (row_in),
    .mask_i   (mask),
    .shift_i  (shift),
    .packed_o (pack_a)
  );

  goe_row_pack u_pack_b (
    .above_i  (next_above),
    .cur_i    (row_new),
    .below_i  ('0),
    .mask_i   (mask),
    .shift_i  (shift),
    .packed_o (pack_b)
  );

  assign res_a.packed_row = pack_a;
  assign res_a.last       = 1'b0;
  assign res_b.packed_row = pack_b;
  assign res_b.last       = 1'b1;
  assign push0            = push_a ? res_a : res_b;

  goe_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (push0),
    .push1_i    (res_b),
    .room_o     (room),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .head_o     (head)
  );

  assign m_axis_tdata = head.packed_row;
  assign m_axis_tlast = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthW'(GridSize);
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q     <= '0;
      pending_q   <= '0;
      rows_seen_q <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        above_q     <= '0;
        pending_q   <= '0;
        rows_seen_q <= '0;
      end else if (!full_glyph) begin
        above_q     <= next_above;
        pending_q   <= row_new;
        rows_seen_q <= rows_seen_q + CntW'(1);
      end
    end
  end

  a_rows_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_seen_q <= CntW'(GridSize))
    else $error("row count beyond grid height");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast |=> rows_seen_q == '0 && pending_q == '0 && above_q == '0)
    else $error("glyph state not cleared after final row");

  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_glyph |-> push_cnt == 2'd0)
    else $error("result produced for a row past the grid");

endmodule

@@ test/tb_glyph_outline_expander.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for glyph_outline_expander: a directed row table, then random glyphs.
// Depends on goe_pkg and the RTL top level; each result is checked against a built-in predictor or the table.
module tb_glyph_outline_expander;
  import goe_pkg::*;

  typedef struct {
    int          wr_width;
    logic [31:0] row;
    logic        last;
    bit          typed;
    logic [31:0] want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [WidthW-1:0]   cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [RowW-1:0]     s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [PackW-1:0]    m_axis_tdata;
  logic                m_axis_tlast;

  logic [WidthW-1:0] glyph_w;
  logic [31:0]       row_above;
  logic [31:0]       row_pending;
  int                rows_seen;
  result_t           want_rows[$];
  int                err_cnt = 0;
  bit                idle_on = 1'b1;
  int                rows_left = 0;

  stim_row_t stim_tab[27] = '{
    '{-1, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{-1, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h5555_5555},
    '{-1, 32'h8000_0000, 1'b1, 1'b1, 32'h6000_0000},
    '{-1, 32'h0100_0000, 1'b0, 1'b0, 32'h0},
    '{-1, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{0,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
    '{31, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h5555_5555},
    '{1,  32'h8000_0000, 1'b1, 1'b1, 32'h0000_0001},
    '{16, 32'hF0F0_0000, 1'b0, 1'b0, 32'h0},
    '{4,  32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{16, 32'h0001_8000, 1'b0, 1'b0, 32'h0},
    '{-1, 32'h8001_0000, 1'b0, 1'b0, 32'h0},
    '{-1, 32'hAAAA_5555, 1'b0, 1'b0, 32'h0},
    '{-1, 32'h5555_AAAA, 1'b0, 1'b0, 32'h0},
    '{-1, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{-1, 32'hFFFF_0000, 1'b0, 1'b0, 32'h0},
    '{-1, 32'h0000_FFFF, 1'b0, 1'b0, 32'h0},
    '{-1, 32'h1248_0000, 1'b0, 1'b0, 32'h0},
    '{-1, 32'h8421_0000, 1'b0, 1'b0, 32'h0},
    '{-1, 32'h0180_0000, 1'b0, 1'b0, 32'h0},
    '{-1, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{-1, 32'h7FFE_0000, 1'b0, 1'b0, 32'h0},
    '{-1, 32'h4002_0000, 1'b0, 1'b0, 32'h0},
    '{-1, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{-1, 32'hC003_0000, 1'b0, 1'b0, 32'h0},
    '{-1, 32'h0001_0000, 1'b0, 1'b0, 32'h0},
    '{-1, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0}
  };

  glyph_outline_expander dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  function automatic int used_width();
    return (int'(glyph_w) > GridSize) ? GridSize : int'(glyph_w);
  endfunction

  function automatic logic [31:0] row_mask(int w);
    return (w == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - w));
  endfunction

  function automatic logic [31:0] outline_codes(logic [31:0] above, logic [31:0] cur,
                                                logic [31:0] below);
    int          w;
    logic [31:0] m;
    logic [31:0] near;
    logic [31:0] rim;
    logic [63:0] v;
    w = used_width();
    m = row_mask(w);
    above &= m;
    cur &= m;
    below &= m;
    near = ((cur << 1) | (cur >> 1) | above | below) & m;
    rim = near & ~cur;
    v = '0;
    for (int x = 0; x < w; x++) begin
      v = v << 2;
      if (cur[31-x]) begin
        v[1:0] = CodeInk;
      end else if (rim[31-x]) begin
        v[1:0] = CodeEdge;
      end
    end
    return v[31:0];
  endfunction

  task automatic expand_row(input logic [31:0] row, input logic lst, output int n,
                            output result_t r0, output result_t r1);
    result_t rr;
    n = 0;
    r0 = '0;
    r1 = '0;
    if (rows_seen >= GridSize) begin
      if (lst) begin
        row_above = '0;
        row_pending = '0;
        rows_seen = 0;
      end
      return;
    end
    if (rows_seen > 0) begin
      r0.packed_row = outline_codes(row_above, row_pending, row);
      r0.last = 1'b0;
      n = 1;
    end
    row_above = (rows_seen > 0) ? row_pending : 32'h0;
    row_pending = row & row_mask(used_width());
    rows_seen++;
    if (lst || rows_seen >= GridSize) begin
      rr.packed_row = outline_codes(row_above, row_pending, 32'h0);
      rr.last = 1'b1;
      if (n == 0) begin
        r0 = rr;
      end else begin
        r1 = rr;
      end
      n++;
      if (lst) begin
        row_above = '0;
        row_pending = '0;
        rows_seen = 0;
      end
    end
  endtask

  task automatic send_row(input logic [31:0] row, input logic lst, input bit typed,
                          input logic [31:0] want);
    int      gap;
    int      n;
    result_t r0;
    result_t r1;
    result_t tr;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= row;
    s_axis_tlast <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    expand_row(row, lst, n, r0, r1);
    if (typed) begin
      tr.packed_row = want;
      tr.last = 1'b1;
      want_rows.push_back(tr);
    end else begin
      if (n > 0) want_rows.push_back(r0);
      if (n > 1) want_rows.push_back(r1);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (want_rows.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [WidthW-1:0] w);
    drain();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    glyph_w = w;
  endtask

  function automatic logic [31:0] random_row();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'h0;
      2: return 32'hFFFF_FFFF;
      3: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (want_rows.size() == 0) begin
        $error("result with no request pending: tdata %h tlast %b", m_axis_tdata,
               m_axis_tlast);
        err_cnt++;
      end else begin
        w = want_rows.pop_front();
        if (m_axis_tdata !== w.packed_row) begin
          $error("packed_row: expected %h, actual %h", w.packed_row, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tlast !== w.last) begin
          $error("last: expected %b, actual %b", w.last, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall = $urandom_range(1, 5) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int          phase_w[7] = '{16, 0, 31, 1, 17, 8, 15};
    logic [31:0] row;
    logic        lst;
    glyph_w = 5'd16;
    row_above = '0;
    row_pending = '0;
    rows_seen = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_tab[i]) begin
      if (stim_tab[i].wr_width >= 0) write_width(stim_tab[i].wr_width[WidthW-1:0]);
      send_row(stim_tab[i].row, stim_tab[i].last, stim_tab[i].typed, stim_tab[i].want);
    end

    for (int p = 0; p < 10; p++) begin
      write_width((p < 7) ? phase_w[p][WidthW-1:0] : WidthW'($urandom_range(0, 31)));
      idle_on = (p != 3 && p != 9);
      for (int k = 0; k < 118; k++) begin
        if (rows_left == 0) begin
          rows_left = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 22)
                                                  : $urandom_range(1, 16);
        end
        lst = (rows_left == 1) || ($urandom_range(0, 40) == 0);
        rows_left = lst ? 0 : rows_left - 1;
        row = random_row();
        send_row(row, lst, 1'b0, 32'h0);
        if ($urandom_range(0, 199) == 0) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
